// ===== src/modexp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the modular
// exponentiation block. No dependencies.
package modexp_pkg;

  localparam int unsigned OPERAND_BITS = 32;
  localparam int unsigned CNT_W        = $clog2(OPERAND_BITS);
  localparam int unsigned IN_TDATA_W   = ((3 * OPERAND_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OPERAND_BITS + 7) / 8) * 8;

  typedef logic [OPERAND_BITS-1:0] operand_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new request from the input channel
    logic step;       // advance the shift-add multiplier by one bit
    logic start_acc;  // start accumulator * square
    logic start_sq;   // start square * square
    logic acc_write;  // store the product into the accumulator
    logic sq_write;   // store the product into the running square
    logic exp_shift;  // drop the lowest exponent bit
    logic out_load;   // move the result into the output register
  } modexp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_special; // zero modulus or zero exponent on the input channel
    logic mul_last;   // multiplier is on its final bit
    logic exp_zero;   // no exponent bits left
    logic exp_lsb;    // lowest remaining exponent bit
  } modexp_status_t;

endpackage

// ===== src/modexp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers, shared shift-add modular multiplier and the
// output register. Depends on modexp_pkg.
module modexp_dp import modexp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  modexp_cmd_t    cmd_i,
  output modexp_status_t status_o,
  input  operand_t       in_base_i,
  input  operand_t       in_exponent_i,
  input  operand_t       in_modulus_i,
  output operand_t       power_result_o,
  output logic           modulus_error_o
);

  localparam int unsigned W = OPERAND_BITS;

  operand_t         acc_q, sq_q, exp_q, mod_q;
  operand_t         a_q, b_q, r_q;
  logic             err_q;
  logic [CNT_W-1:0] cnt_q;
  operand_t         out_res_q;
  logic             out_err_q;

  operand_t         addend;
  operand_t         one_mod;
  operand_t         load_acc;
  operand_t         r_next;
  logic [W+1:0]     t_sum, t_sub1, t_sub2, n1, n2;

  // One multiplier bit: r = (2r + bit*a) mod n. With r, a < n the sum stays
  // below 3n, so one of three candidates is the reduced value.
  always_comb begin
    addend = b_q[W-1] ? a_q : '0;
    t_sum  = {1'b0, r_q, 1'b0} + {2'b00, addend};
    n1     = {2'b00, mod_q};
    n2     = {1'b0, mod_q, 1'b0};
    t_sub1 = t_sum - n1;
    t_sub2 = t_sum - n2;
    if (t_sum >= n2) begin
      r_next = t_sub2[W-1:0];
    end else if (t_sum >= n1) begin
      r_next = t_sub1[W-1:0];
    end else begin
      r_next = t_sum[W-1:0];
    end
  end

  // 1 mod n; also seeds the base reduction, which runs as (1 * base) mod n
  assign one_mod = (in_modulus_i == operand_t'(1)) ? '0 : operand_t'(1);

  always_comb begin
    priority if (in_modulus_i == '0) begin
      load_acc = '0;
    end else if (in_exponent_i == '0) begin
      load_acc = operand_t'(1);
    end else begin
      load_acc = one_mod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.start_acc || cmd_i.start_sq) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= status_o.mul_last ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.load) begin
      mod_q <= in_modulus_i;
      exp_q <= in_exponent_i;
      acc_q <= load_acc;
      err_q <= (in_modulus_i == '0);
      a_q   <= one_mod;
      b_q   <= in_base_i;
      r_q   <= '0;
    end else begin
      if (cmd_i.acc_write) begin
        acc_q <= r_next;
      end
      if (cmd_i.sq_write) begin
        sq_q <= r_next;
      end
      if (cmd_i.exp_shift) begin
        exp_q <= exp_q >> 1;
      end
      priority if (cmd_i.start_acc) begin
        a_q <= acc_q;
        b_q <= sq_q;
        r_q <= '0;
      end else if (cmd_i.start_sq) begin
        a_q <= sq_q;
        b_q <= sq_q;
        r_q <= '0;
      end else if (cmd_i.step) begin
        r_q <= r_next;
        b_q <= b_q << 1;
      end else begin
        // hold the multiplier while idle, checking or finishing
        r_q <= r_q;
      end
    end
    if (cmd_i.out_load) begin
      out_res_q <= acc_q;
      out_err_q <= err_q;
    end
  end

  assign status_o.in_special = (in_modulus_i == '0) || (in_exponent_i == '0);
  assign status_o.mul_last   = (cnt_q == CNT_W'(W - 1));
  assign status_o.exp_zero   = (exp_q == '0);
  assign status_o.exp_lsb    = exp_q[0];

  assign power_result_o  = out_res_q;
  assign modulus_error_o = out_err_q;

endmodule

// ===== src/modexp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the base reduction, multiply and square passes and
// owns both handshakes. Depends on modexp_pkg.
module modexp_ctrl import modexp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  modexp_status_t status_i,
  output modexp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_REDUCE  = 6'b000010,
    S_CHECK   = 6'b000100,
    S_MUL_ACC = 6'b001000,
    S_MUL_SQ  = 6'b010000,
    S_FINISH  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_special ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.step = 1'b1;
        if (status_i.mul_last) begin
          cmd_o.sq_write = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (status_i.exp_zero) begin
          state_d = S_FINISH;
        end else if (status_i.exp_lsb) begin
          cmd_o.start_acc = 1'b1;
          state_d         = S_MUL_ACC;
        end else begin
          cmd_o.start_sq = 1'b1;
          state_d        = S_MUL_SQ;
        end
      end
      S_MUL_ACC: begin
        cmd_o.step = 1'b1;
        if (status_i.mul_last) begin
          cmd_o.acc_write = 1'b1;
          cmd_o.start_sq  = 1'b1;
          state_d         = S_MUL_SQ;
        end
      end
      S_MUL_SQ: begin
        cmd_o.step = 1'b1;
        if (status_i.mul_last) begin
          cmd_o.sq_write  = 1'b1;
          cmd_o.exp_shift = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten while still pending");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("request accepted while previous one still in work");

  a_special_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && status_i.in_special) |=> (state_q == S_FINISH))
    else $error("special request did not bypass the multiplier");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && status_i.exp_zero) |=> (state_q == S_FINISH))
    else $error("exponent scan did not end when exponent ran out");

endmodule

// ===== src/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on modexp_pkg, modexp_ctrl and modexp_dp.
//
//  Channel  Dir  tdata (low bit up)                   tuser
//  s_axis   in   base, exponent, modulus (96 bits)     -
//  m_axis   out  power_result (32 bits)                modulus_error
//
// One request at a time. A normal request runs the base reduction, then per
// exponent bit a check, a multiply pass if the bit is set and a square pass,
// then a last check and the finish state; passes use the single shift-add
// multiplier, one bit per cycle. A zero modulus or exponent skips to finish.
// Reset is asynchronous, active low, and returns the block to idle.
// A result waiting on m_axis does not block the next request; that request
// holds in its final cycle until the output register is free.
module modular_exponentiation import modexp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // base, exponent, modulus
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // power_result
  output logic                   m_axis_tuser_o   // modulus_error
);

  modexp_cmd_t    cmd;
  modexp_status_t status;
  operand_t       power_result;

  modexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  modexp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_base_i       (s_axis_tdata_i[OPERAND_BITS-1:0]),
    .in_exponent_i   (s_axis_tdata_i[2*OPERAND_BITS-1:OPERAND_BITS]),
    .in_modulus_i    (s_axis_tdata_i[3*OPERAND_BITS-1:2*OPERAND_BITS]),
    .power_result_o  (power_result),
    .modulus_error_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(power_result);

endmodule

// ===== tb/sv/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation: directed table, then random requests; rows
// not typed by inspection are checked against a double-width square-and-multiply predictor. Depends on modexp_pkg.
module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 280;
  localparam int unsigned DIRECTED_ROWS   = 21;
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int unsigned PRINT_LIMIT     = 40;

  typedef struct packed {
    operand_t power_result;
    logic     modulus_error;
  } power_reply_t;

  typedef struct packed {
    operand_t     base;
    operand_t     exponent;
    operand_t     modulus;
    logic         typed;      // reply below is known by inspection
    power_reply_t reply;
  } req_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // base, exponent, modulus
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // power_result
  logic                   m_axis_tuser_o;   // modulus_error

  power_reply_t pending_powers[$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  stall_left;
  bit           calm;

  // Zero modulus wins over zero exponent; zero exponent gives 1 even for modulus one.
  req_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'd5,          32'd0,          32'd0,          1'b1, '{32'd0, 1'b1}},
    '{32'd7,          32'd13,         32'd0,          1'b1, '{32'd0, 1'b1}},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          1'b1, '{32'd0, 1'b1}},
    '{32'd9,          32'd0,          32'd1,          1'b1, '{32'd1, 1'b0}},
    '{32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF,  1'b1, '{32'd1, 1'b0}},
    '{32'd0,          32'd0,          32'd5,          1'b1, '{32'd1, 1'b0}},
    '{32'd123,        32'd1,          32'd1,          1'b1, '{32'd0, 1'b0}},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1,          1'b1, '{32'd0, 1'b0}},
    '{32'd0,          32'd5,          32'd97,         1'b1, '{32'd0, 1'b0}},
    '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{32'd1, 1'b0}},
    '{32'd2,          32'd10,         32'd1000,       1'b1, '{32'd24, 1'b0}},
    '{32'd3,          32'd1,          32'd7,          1'b1, '{32'd3, 1'b0}},
    '{32'd10,         32'd1,          32'd7,          1'b1, '{32'd3, 1'b0}},
    '{32'd7,          32'd2,          32'd2,          1'b1, '{32'd1, 1'b0}},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{32'd0, 1'b0}},
    '{32'hFFFF_FFFE,  32'd2,          32'hFFFF_FFFF,  1'b1, '{32'd1, 1'b0}},
    '{32'd2,          32'd31,         32'hFFFF_FFFF,  1'b1, '{32'h8000_0000, 1'b0}},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFB,  1'b0, '{32'd0, 1'b0}},
    '{32'h1234_5678,  32'h8000_0000,  32'hFFFF_FFFE,  1'b0, '{32'd0, 1'b0}},
    '{32'h8000_0000,  32'd3,          32'h8000_0001,  1'b0, '{32'd0, 1'b0}},
    '{32'hDEAD_BEEF,  32'd65537,      32'hC000_0001,  1'b0, '{32'd0, 1'b0}}
  };

  modular_exponentiation dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Right-to-left square-and-multiply with exact 64-bit products.
  function automatic power_reply_t predict_power(operand_t b, operand_t e, operand_t m);
    power_reply_t reply;
    bit [63:0]    acc;
    bit [63:0]    sq;
    bit [63:0]    n;
    operand_t     rest;
    reply.power_result  = '0;
    reply.modulus_error = 1'b0;
    if (m == '0) begin
      reply.modulus_error = 1'b1;
    end else if (e == '0) begin
      reply.power_result = 1;
    end else begin
      n    = 64'(m);
      acc  = 64'd1 % n;
      sq   = 64'(b) % n;
      rest = e;
      while (rest != '0) begin
        if (rest[0]) acc = (acc * sq) % n;
        sq   = (sq * sq) % n;
        rest = rest >> 1;
      end
      reply.power_result = acc[OPERAND_BITS-1:0];
    end
    return reply;
  endfunction

  // Mostly back-to-back (always while calm), sometimes a short gap, now and then a long hold.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(input operand_t b, input operand_t e, input operand_t m,
                              input logic typed, input power_reply_t typed_reply);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {m, e, b};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_powers.push_back(typed ? typed_reply : predict_power(b, e, m));
  endtask

  // Hold off the sender until every outstanding request has returned.
  task automatic drain_requests();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  task automatic make_random_request(output operand_t b, output operand_t e,
                                     output operand_t m);
    int unsigned kind;
    int unsigned e_bits;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       m = $urandom_range(2, 1000);
      1:       m = $urandom | 32'h8000_0000;
      default: m = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       b = 0;
      1:       b = 32'hFFFF_FFFF;
      2:       b = (m > 1) ? operand_t'($urandom % m) : operand_t'($urandom);
      default: b = $urandom;
    endcase
    if ($urandom_range(0, 9) < 3) begin
      e = $urandom;
    end else begin
      e_bits = $urandom_range(1, 12);
      e = operand_t'($urandom) & ((operand_t'(1) << e_bits) - 1);
    end
    if (kind < 5) begin
      m = 0;
    end else if (kind < 10) begin
      e = 0;
    end else if (kind < 13) begin
      m = 1;
    end
  endtask

  // Check results and drive the receiver stall pattern.
  always @(posedge clk_i) begin
    power_reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_powers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
          $display("%0t: unexpected result: expected none, actual power_result=%h error=%b",
                   $time, m_axis_tdata_o[OPERAND_BITS-1:0], m_axis_tuser_o);
      end else begin
        want = pending_powers.pop_front();
        if (m_axis_tdata_o[OPERAND_BITS-1:0] !== want.power_result) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: power_result mismatch: expected %h, actual %h",
                     $time, want.power_result, m_axis_tdata_o[OPERAND_BITS-1:0]);
        end
        if (m_axis_tuser_o !== want.modulus_error) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: modulus_error mismatch: expected %b, actual %b",
                     $time, want.modulus_error, m_axis_tuser_o);
        end
      end
    end
    if (calm) begin
      m_axis_tready_i <= 1'b1;
      stall_left      <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 99) < 8)
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                 : $urandom_range(15, 80);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    operand_t rb;
    operand_t re;
    operand_t rm;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    stall_left      = 0;
    calm            = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].base, directed_rows[i].exponent,
                   directed_rows[i].modulus, directed_rows[i].typed,
                   directed_rows[i].reply);
    drain_requests();

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 120 && n < 160);
      if (n == 200) drain_requests();
      make_random_request(rb, re, rm);
      send_request(rb, re, rm, 1'b0, '0);
    end
    calm = 1'b0;

    drain_requests();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/modexp_pkg.sv
src/modexp_dp.sv
src/modexp_ctrl.sv
src/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
